// ===== rtl/assert_macros.svh =====
// Assertion helper macros shared by the line rasterizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, quiet while reset is held.
`define AST_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Plain invariant checked every cycle.
`define AST_ALWAYS(lbl, clk, rstn, expr, msg) \
  `AST_PROP(lbl, clk, rstn, (expr), msg)

`endif

// ===== rtl/fplr_pkg.sv =====
// Shared types, constants and microcode ROM for the fixed-point line rasterizer.
`timescale 1ns / 1ps
package fplr_pkg;

  localparam int IN_COORD_W  = 10;
  localparam int COLOR_W     = 8;
  localparam int PIX_W       = 12;
  localparam int OFF_W       = 20;
  localparam int PITCH_W     = 11;
  localparam int IN_TDATA_W  = 4 * IN_COORD_W + COLOR_W;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * PIX_W - OFF_W - COLOR_W;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 11'd1024;

  // opcode carried in tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // microcode addresses
  localparam int UA_W = 3;
  localparam logic [UA_W-1:0] UA_FETCH = 3'd0;
  localparam logic [UA_W-1:0] UA_DIV   = 3'd1;
  localparam logic [UA_W-1:0] UA_STORE = 3'd2;
  localparam logic [UA_W-1:0] UA_EMIT  = 3'd3;
  localparam logic [UA_W-1:0] UA_OUT   = 3'd4;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_GOTO,
    SEQ_DISPATCH,
    SEQ_LOOP_DIV,
    SEQ_WAIT_OUT
  } seq_op_e;

  typedef struct packed {
    logic            take_in;
    logic            div_step;
    logic            store_minor;
    logic            emit;
    logic            load_out;
    seq_op_e         seq_op;
    logic [UA_W-1:0] target;
  } ucode_t;

  // strobes from sequencer to datapath
  typedef struct packed {
    logic take_in;
    logic setup;
    logic div_step;
    logic store_minor;
    logic emit;
    logic load_out;
  } ctrl_t;

  // datapath status for conditional jumps
  typedef struct packed {
    logic active;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic ucode_t ucode_rom(input logic [UA_W-1:0] addr);
    ucode_t w;
    w = '{take_in: 1'b0, div_step: 1'b0, store_minor: 1'b0, emit: 1'b0,
          load_out: 1'b0, seq_op: SEQ_GOTO, target: UA_FETCH};
    case (addr)
      UA_FETCH: begin
        w.take_in = 1'b1;
        w.seq_op  = SEQ_DISPATCH;
        w.target  = UA_DIV;
      end
      UA_DIV: begin
        w.div_step = 1'b1;
        w.seq_op   = SEQ_LOOP_DIV;
      end
      UA_STORE: begin
        w.store_minor = 1'b1;
        w.seq_op      = SEQ_GOTO;
        w.target      = UA_FETCH;
      end
      UA_EMIT: begin
        w.emit   = 1'b1;
        w.seq_op = SEQ_NEXT;
      end
      UA_OUT: begin
        w.load_out = 1'b1;
        w.seq_op   = SEQ_WAIT_OUT;
        w.target   = UA_FETCH;
      end
      default: begin
        w.seq_op = SEQ_GOTO;
        w.target = UA_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/fplr_div.sv =====
// Restoring divider, one quotient bit per cycle while step_i is high, for the minor-axis step.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fplr_div import fplr_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    step_i,
  input  logic [COORD_BITS:0]     mag_i,
  input  logic [COORD_BITS:0]     len_i,
  output logic [FRAC_BITS:0]      quot_o,
  output logic                    done_o
);

  localparam int LEN_W = COORD_BITS + 1;
  localparam int REM_W = COORD_BITS + 2;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  logic [LEN_W-1:0] rem_q, rem_d, len_q;
  logic [Q_W-1:0]   quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             first_q, first_d;
  logic [REM_W-1:0] trial, diff;
  logic             ge;

  assign done_o = (cnt_q == '0);
  assign quot_o = quot_q;

  // first bit compares the remainder unshifted (mag never exceeds len)
  always_comb begin
    trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge    = (trial >= {1'b0, len_q});
    diff  = trial - {1'b0, len_q};
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    if (start_i) begin
      rem_d   = mag_i;
      quot_d  = '0;
      cnt_d   = CNT_W'(Q_W);
      first_d = 1'b1;
    end else if (step_i && !done_o) begin
      rem_d   = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quot_d  = {quot_q[Q_W-2:0], ge};
      cnt_d   = cnt_q - CNT_W'(1);
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= 1'b0;
      quot_q  <= '0;
    end else begin
      cnt_q   <= cnt_d;
      first_q <= first_d;
      quot_q  <= quot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (start_i) begin
      len_q <= len_i;
    end
  end

  // quotient of (mag << FRAC) / len with mag <= len never passes one unit
  `AST_ALWAYS(a_quot_bound, clk_i, rst_ni, !done_o || quot_q <= (Q_W'(1) << FRAC_BITS), "divider quotient above one unit")

endmodule

// ===== rtl/fplr_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fplr_seq import fplr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    opcode_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [UA_W-1:0] pc_q, pc_d;
  ucode_t          word;
  logic            accept;

  assign word   = ucode_rom(pc_q);
  assign accept = word.take_in & in_valid_i;

  always_comb begin
    ctrl_o.take_in     = word.take_in;
    ctrl_o.setup       = accept & (opcode_i == OP_START);
    ctrl_o.div_step    = word.div_step;
    ctrl_o.store_minor = word.store_minor;
    ctrl_o.emit        = word.emit;
    ctrl_o.load_out    = word.load_out & status_i.out_free;
  end

  always_comb begin
    case (word.seq_op)
      SEQ_NEXT:     pc_d = pc_q + UA_W'(1);
      SEQ_GOTO:     pc_d = word.target;
      SEQ_DISPATCH: begin
        if (accept && opcode_i == OP_START) begin
          pc_d = word.target;
        end else if (accept && opcode_i == OP_STEP && status_i.active) begin
          pc_d = UA_EMIT;
        end else begin
          pc_d = pc_q;
        end
      end
      SEQ_LOOP_DIV: pc_d = status_i.div_done ? pc_q + UA_W'(1) : pc_q;
      SEQ_WAIT_OUT: pc_d = status_i.out_free ? word.target : pc_q;
      default:      pc_d = UA_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UA_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  `AST_PROP(a_div_loop, clk_i, rst_ni, (pc_q == UA_DIV && !status_i.div_done) |=> (pc_q == UA_DIV), "left divide loop early")
  `AST_PROP(a_setup_div, clk_i, rst_ni, ctrl_o.setup |=> (pc_q == UA_DIV && !status_i.div_done), "line start did not enter divide")

endmodule

// ===== rtl/fplr_dp.sv =====
// Datapath: line setup, accumulators, pixel offset and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fplr_dp import fplr_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output status_t               status_o,
  input  logic [IN_COORD_W-1:0] start_x_i,
  input  logic [IN_COORD_W-1:0] start_y_i,
  input  logic [IN_COORD_W-1:0] end_x_i,
  input  logic [IN_COORD_W-1:0] end_y_i,
  input  logic [COLOR_W-1:0]    color_i,
  input  logic [PITCH_W-1:0]    pitch_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [PIX_W-1:0]      pixel_x_o,
  output logic [PIX_W-1:0]      pixel_y_o,
  output logic [OFF_W-1:0]      pixel_offset_o,
  output logic [COLOR_W-1:0]    pixel_color_o,
  output logic                  last_o
);

  localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;
  localparam int LEN_W = COORD_BITS + 1;
  localparam int POS_W = COORD_BITS + 2;
  localparam logic [ACC_W-1:0] UNIT = ACC_W'(1) << FRAC_BITS;

  // setup terms
  logic [COORD_BITS-1:0]   x0, y0, x1, y1;
  logic signed [LEN_W-1:0] dx, dy, minor_diff;
  logic [LEN_W-1:0]        adx, ady, len, mag, abs_minor;
  logic                    x_major;

  // state
  logic [ACC_W-1:0]   x_acc_q, y_acc_q, x_step_q, y_step_q;
  logic [LEN_W-1:0]   left_q;
  logic [COLOR_W-1:0] color_q;
  logic               active_q, x_major_q, minor_neg_q;

  // emit stage
  logic [POS_W-1:0]         col, row, col_q, row_q;
  logic [OFF_W-1:0]         row_ext, col_ext, prod_q;
  logic [OFF_W+PITCH_W-1:0] prod;
  logic                     last_q;

  // minor step from the divider
  logic [FRAC_BITS:0] quot;
  logic               div_done;
  logic [ACC_W-1:0]   minor_step;

  // output word
  logic               out_valid_q, out_free;
  logic [PIX_W-1:0]   px_q, py_q;
  logic [OFF_W-1:0]   off_q;
  logic [COLOR_W-1:0] ocolor_q;
  logic               olast_q;

  always_comb begin
    x0 = COORD_BITS'(start_x_i);
    y0 = COORD_BITS'(start_y_i);
    x1 = COORD_BITS'(end_x_i);
    y1 = COORD_BITS'(end_y_i);
    dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
    dy = $signed({1'b0, y1}) - $signed({1'b0, y0});
    adx = dx[LEN_W-1] ? $unsigned(-dx) : $unsigned(dx);
    ady = dy[LEN_W-1] ? $unsigned(-dy) : $unsigned(dy);
    x_major    = (adx >= ady);
    len        = (x_major ? adx : ady) + LEN_W'(1);
    minor_diff = x_major ? dy : dx;
    abs_minor  = x_major ? ady : adx;
    mag        = abs_minor + LEN_W'(1);
  end

  fplr_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.setup),
    .step_i  (ctrl_i.div_step),
    .mag_i   (mag),
    .len_i   (len),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  assign minor_step = minor_neg_q ? -ACC_W'(quot) : ACC_W'(quot);

  // floor(accum / 2^FRAC) is the upper slice
  assign col     = x_acc_q[ACC_W-1:FRAC_BITS];
  assign row     = y_acc_q[ACC_W-1:FRAC_BITS];
  assign row_ext = {{(OFF_W-POS_W){row[POS_W-1]}}, row};
  assign col_ext = {{(OFF_W-POS_W){col_q[POS_W-1]}}, col_q};
  assign prod    = (OFF_W+PITCH_W)'(row_ext) * (OFF_W+PITCH_W)'(pitch_i);

  assign out_free = !out_valid_q || out_ready_i;
  assign status_o = '{active: active_q, div_done: div_done, out_free: out_free};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.setup) begin
        active_q <= 1'b1;
      end else if (ctrl_i.emit && left_q == LEN_W'(1)) begin
        active_q <= 1'b0;
      end
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.setup) begin
      x_acc_q     <= ACC_W'(x0) << FRAC_BITS;
      y_acc_q     <= ACC_W'(y0) << FRAC_BITS;
      left_q      <= len;
      color_q     <= color_i;
      x_major_q   <= x_major;
      minor_neg_q <= minor_diff[LEN_W-1];
      if (x_major) begin
        x_step_q <= dx[LEN_W-1] ? -UNIT : UNIT;
      end else begin
        y_step_q <= dy[LEN_W-1] ? -UNIT : UNIT;
      end
    end else if (ctrl_i.store_minor) begin
      if (x_major_q) begin
        y_step_q <= minor_step;
      end else begin
        x_step_q <= minor_step;
      end
    end else if (ctrl_i.emit) begin
      x_acc_q <= x_acc_q + x_step_q;
      y_acc_q <= y_acc_q + y_step_q;
      left_q  <= left_q - LEN_W'(1);
    end
    if (ctrl_i.emit) begin
      col_q  <= col;
      row_q  <= row;
      prod_q <= prod[OFF_W-1:0];
      last_q <= (left_q == LEN_W'(1));
    end
    if (ctrl_i.load_out) begin
      px_q     <= PIX_W'($signed(col_q));
      py_q     <= PIX_W'($signed(row_q));
      off_q    <= prod_q + col_ext;
      ocolor_q <= color_q;
      olast_q  <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_offset_o = off_q;
  assign pixel_color_o  = ocolor_q;
  assign last_o         = olast_q;

  `AST_PROP(a_emit_active, clk_i, rst_ni, ctrl_i.emit |-> active_q, "pixel emitted with no line active")
  `AST_PROP(a_end_on_emit, clk_i, rst_ni, $fell(active_q) |-> $past(ctrl_i.emit), "line ended outside a pixel step")
  `AST_PROP(a_no_overwrite, clk_i, rst_ni, ctrl_i.load_out |-> out_free, "output word overwritten while held")

endmodule

// ===== rtl/fixed_point_line_rasterizer.sv =====
// Top level of the fixed-point DDA line rasterizer.
`timescale 1ns / 1ps
// Usage:
//  - Input stream s_axis: tuser carries the opcode (start a line or request a
//    pixel), tdata the endpoints and color. A start word computes the walk and
//    gives no output; each pixel-request word gives one output word while a
//    line is active, none when idle. A start during a line drops that line.
//  - Output stream m_axis: one word per pixel (column, row, buffer offset,
//    color), tlast on the final pixel of the line.
//  - cfg channel: writes row_pitch; always ready, write only while idle.
// Sequencing (microcoded sequencer, one control word per cycle):
//  - Start word: busy while the one-bit-per-cycle divider loop forms the
//    minor-axis step, then in the step that stores it.
//  - Pixel word: accepted in the fetch step, then the emit step (offset multiply)
//    and the output-load step; the next word is taken only after that load.
// Reset (async, active low): idle, no line active, row_pitch = 1024.
// Stall: the output register holds a finished pixel while the next word is
// taken; the sequencer waits in its output-load step only if a second pixel
// is ready before the first one has drained.
module fixed_point_line_rasterizer import fplr_pkg::*; #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // pixel stream in
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // start_x, start_y, end_x, end_y, color
  input  logic [0:0]             s_axis_tuser_i,  // opcode
  // pixel stream out
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // pixel_x, pixel_y, pixel_offset,
                                                  // pixel_color, zero pad
  output logic                   m_axis_tlast_o,  // last pixel of the line
  // row pitch register write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [PITCH_W-1:0]     cfg_data_i
);

  ctrl_t   ctrl;
  status_t status;

  logic [PITCH_W-1:0] pitch_q;
  logic [PIX_W-1:0]   pixel_x, pixel_y;
  logic [OFF_W-1:0]   pixel_offset;
  logic [COLOR_W-1:0] pixel_color;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= PITCH_RESET;
    end else if (cfg_valid_i) begin
      pitch_q <= cfg_data_i;
    end
  end

  assign s_axis_tready_o = ctrl.take_in;

  fplr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .opcode_i   (s_axis_tuser_i[0]),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  fplr_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .start_x_i      (s_axis_tdata_i[IN_COORD_W-1:0]),
    .start_y_i      (s_axis_tdata_i[2*IN_COORD_W-1:IN_COORD_W]),
    .end_x_i        (s_axis_tdata_i[3*IN_COORD_W-1:2*IN_COORD_W]),
    .end_y_i        (s_axis_tdata_i[4*IN_COORD_W-1:3*IN_COORD_W]),
    .color_i        (s_axis_tdata_i[IN_TDATA_W-1:4*IN_COORD_W]),
    .pitch_i        (pitch_q),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_offset_o (pixel_offset),
    .pixel_color_o  (pixel_color),
    .last_o         (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, pixel_color, pixel_offset, pixel_y, pixel_x};

endmodule

// ===== tb/sv/line_pixel_checker.sv =====
// Checker for the line rasterizer: predicts pixel words and compares them with the output stream.
`timescale 1ns / 1ps
module line_pixel_checker import fplr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  input  logic                   s_ready_i,
  input  logic [IN_TDATA_W-1:0]  s_data_i,   // start_x, start_y, end_x, end_y, color
  input  logic [0:0]             s_user_i,   // opcode
  input  logic                   m_valid_i,
  input  logic                   m_ready_i,
  input  logic [OUT_TDATA_W-1:0] m_data_i,   // pixel_x, pixel_y, pixel_offset, pixel_color, pad
  input  logic                   m_last_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [PITCH_W-1:0]     cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int FRAC = 10;
  localparam int UNIT = 1 << FRAC;

  typedef struct packed {
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
    logic [OFF_W-1:0]   offset;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  // predicted walk state
  logic signed [21:0] x_acc, y_acc, x_stp, y_stp;
  logic [10:0]        left;
  logic [COLOR_W-1:0] line_col;
  logic               drawing;
  logic [PITCH_W-1:0] pitch;

  pixel_t pixel_queue[$];
  pixel_t want, got;
  int     mismatches;

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    mismatches++;
  endtask

  function automatic int minor_step(input int diff, input int len);
    int mag, q;
    mag = (diff >= 0) ? diff + 1 : 1 - diff;
    q = (mag * UNIT) / len;
    return (diff >= 0) ? q : -q;
  endfunction

  task setup_line(input logic [IN_TDATA_W-1:0] d);
    int x0, y0, x1, y1, dx, dy, adx, ady, len;
    x0 = int'(d[9:0]);
    y0 = int'(d[19:10]);
    x1 = int'(d[29:20]);
    y1 = int'(d[39:30]);
    dx = x1 - x0;
    dy = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (adx >= ady) begin
      len = adx + 1;
      x_stp = 22'((x0 > x1) ? -UNIT : UNIT);
      y_stp = 22'(minor_step(dy, len));
    end else begin
      len = ady + 1;
      y_stp = 22'((y0 > y1) ? -UNIT : UNIT);
      x_stp = 22'(minor_step(dx, len));
    end
    x_acc = 22'(x0 * UNIT);
    y_acc = 22'(y0 * UNIT);
    left = 11'(len);
    line_col = d[47:40];
    drawing = (left != 0);
  endtask

  // one pixel of the current line, then advance the walk
  task walk_pixel(output pixel_t p);
    logic signed [21:0] cx, cy;
    longint r, c, pt, off;
    cx = x_acc >>> FRAC;
    cy = y_acc >>> FRAC;
    r = longint'(cy);
    c = longint'(cx);
    pt = longint'(pitch);
    off = r * pt + c;
    p.col = cx[PIX_W-1:0];
    p.row = cy[PIX_W-1:0];
    p.offset = off[OFF_W-1:0];
    p.color = line_col;
    p.last = (left == 11'd1);
    x_acc = x_acc + x_stp;
    y_acc = y_acc + y_stp;
    left = left - 11'd1;
    if (left == 11'd0) drawing = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_acc = '0;
      y_acc = '0;
      x_stp = '0;
      y_stp = '0;
      left = '0;
      line_col = '0;
      drawing = 1'b0;
      pitch = PITCH_RESET;
      mismatches = 0;
      pixel_queue.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = '{col: m_data_i[11:0], row: m_data_i[23:12], offset: m_data_i[43:24],
                color: m_data_i[51:44], last: m_last_i};
        if (pixel_queue.size() == 0) begin
          report_mismatch("pixel word with none pending", 64'd0, longint'(m_data_i));
        end else begin
          want = pixel_queue.pop_front();
          if (got.col != want.col)
            report_mismatch("pixel_x", longint'(want.col), longint'(got.col));
          if (got.row != want.row)
            report_mismatch("pixel_y", longint'(want.row), longint'(got.row));
          if (got.offset != want.offset)
            report_mismatch("pixel_offset", longint'(want.offset), longint'(got.offset));
          if (got.color != want.color)
            report_mismatch("pixel_color", longint'(want.color), longint'(got.color));
          if (got.last != want.last)
            report_mismatch("tlast", longint'(want.last), longint'(got.last));
        end
      end
      if (cfg_valid_i && cfg_ready_i) pitch = cfg_data_i;
      if (s_valid_i && s_ready_i) begin
        if (s_user_i == OP_START) begin
          setup_line(s_data_i);
        end else if (drawing) begin
          walk_pixel(want);
          pixel_queue.push_back(want);
        end
      end
      fail_count_o <= mismatches;
      pending_o <= pixel_queue.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the line rasterizer testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import fplr_pkg::*;

  // a slow correct run stays far below this
  localparam int LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data = '0;   // start_x, start_y, end_x, end_y, color
  logic [0:0]             s_user = OP_STEP;   // opcode
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;   // pixel_x, pixel_y, pixel_offset, pixel_color, pad
  logic                   m_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [PITCH_W-1:0]     cfg_data = '0;

  int fail_count, pending;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;   // no idling on either side in the closing phase

  fixed_point_line_rasterizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  line_pixel_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_ready),
    .s_data_i    (s_data),
    .s_user_i    (s_user),
    .m_valid_i   (m_valid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_data),
    .m_last_i    (m_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // output side: tready held high or low in bursts, high twice as often,
  // so long stall-free stretches also occur
  always @(posedge clk) begin
    if (calm) begin
      m_ready <= 1'b1;
    end else if (stall_left == 0) begin
      m_ready <= ($urandom_range(0, 2) != 0);
      stall_left <= $urandom_range(1, 16);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // One input word; an idle burst may come first. tvalid is left high after
  // the handshake so back-to-back words need no second assignment per step.
  task automatic send_word(input logic op, input logic [IN_TDATA_W-1:0] d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= d;
    do @(posedge clk); while (!s_ready);
  endtask

  // start word, then a number of pixel requests carrying junk payload
  task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                           input int color, input int steps);
    send_word(OP_START, {color[7:0], y1[9:0], x1[9:0], y0[9:0], x0[9:0]});
    repeat (steps) send_word(OP_STEP, IN_TDATA_W'({$urandom, $urandom}));
  endtask

  function automatic int line_len(input int x0, input int y0, input int x1, input int y1);
    int adx, ady;
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    return ((adx > ady) ? adx : ady) + 1;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
  endfunction

  // Close a phase: finish with a one-pixel line so the block is left idle,
  // hold off until every predicted pixel is out, then let the divider settle.
  task automatic settle_phase();
    draw_line(7, 9, 7, 9, $urandom_range(0, 255), 1);
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_pitch(input logic [PITCH_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete short lines at random places; some long lines cut off by
  // the next start, and some loose pixel requests (often to an idle block).
  task automatic random_lines(input int n);
    int sent, kind, span, x0, y0, x1, y1, steps;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      x0 = $urandom_range(0, 1023);
      y0 = $urandom_range(0, 1023);
      if (kind < 7) begin
        span = ($urandom_range(0, 1) == 0) ? 8 : 40;
        x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
        y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
        steps = line_len(x0, y0, x1, y1) + $urandom_range(0, 1);
        draw_line(x0, y0, x1, y1, $urandom_range(0, 255), steps);
      end else if (kind < 9) begin
        x1 = $urandom_range(0, 1023);
        y1 = $urandom_range(0, 1023);
        steps = $urandom_range(0, 12);
        draw_line(x0, y0, x1, y1, $urandom_range(0, 255), steps);
      end else begin
        steps = $urandom_range(1, 4);
        repeat (steps) send_word(OP_STEP, IN_TDATA_W'({$urandom, $urandom}));
      end
      sent += steps + ((kind < 9) ? 1 : 0);
    end
  endtask

  initial begin
    logic [PITCH_W-1:0] pitches[6];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset pitch
    send_word(OP_STEP, '1);                     // pixel request while idle
    draw_line(0, 0, 1023, 1023, 255, 3);        // corner to corner, cut short
    draw_line(1023, 1023, 0, 0, 0, 3);          // restart mid-line, walking backward
    draw_line(5, 5, 5, 5, 8'h5a, 2);            // single pixel, then idle request
    draw_line(2, 0, 0, 5, 8'ha5, 7);            // steep, minor axis overshoots below zero
    draw_line(0, 1023, 6, 1021, 8'h3c, 7);      // shallow, minor axis falling
    settle_phase();

    // pitch extremes, out-of-range values and random settings
    pitches[0] = 11'd1;
    pitches[1] = 11'd2047;
    pitches[2] = 11'd0;
    pitches[3] = 11'd1024;
    pitches[4] = PITCH_W'($urandom_range(1, 1024));
    pitches[5] = PITCH_W'($urandom_range(0, 2047));
    foreach (pitches[i]) begin
      if (i == 5) calm = 1'b1;
      write_pitch(pitches[i]);
      random_lines(85);
      settle_phase();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fplr_pkg.sv
rtl/fplr_div.sv
rtl/fplr_seq.sv
rtl/fplr_dp.sv
rtl/fixed_point_line_rasterizer.sv
tb/sv/line_pixel_checker.sv
tb/sv/testbench.sv
